/* sv/rmm_pkg.sv */
// Package for the running min/max block: payload structs, constants and the
// binary64 compare helper. No dependencies.
`default_nettype none
package rmm_pkg;
  localparam logic [63:0] BITS_PLUS_ONE = 64'h3FF0000000000000;
  localparam logic [63:0] BITS_MINUS_ONE = 64'hBFF0000000000000;
  localparam logic [31:0] NO_POS = 32'hFFFFFFFF;
  localparam logic [30:0] COUNT_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic [63:0] sample_bits;
    logic [30:0] sample_position;
    logic        last_in_run;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        max_bits;
    logic [63:0]        min_bits;
    logic signed [31:0] max_position;
    logic signed [31:0] min_position;
    logic               has_finite;
    logic signed [31:0] first_finite_position;
    logic signed [31:0] last_finite_position;
    logic [30:0]        point_count;
  } out_item_t;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic [63:0] bits;
    logic [30:0] pos;
    logic        finite;
    logic        last;
  } cls_item_t;

  // Maps binary64 bits of a finite value to an unsigned key that orders like
  // the value; both zeros map to the same key.
  function automatic logic [63:0] order_key(input logic [63:0] b);
    logic [63:0] k;
    if (b[62:0] == 63'd0) begin
      k = 64'h8000000000000000;
    end else if (b[63]) begin
      k = ~b;
    end else begin
      k = b | 64'h8000000000000000;
    end
    return k;
  endfunction
endpackage
`default_nettype wire

/* sv/rmm_front.sv */
// Front stage: accepts samples, classifies them as finite, and holds them in
// a two-entry queue for the back stage. Depends on rmm_pkg.
`default_nettype none
module rmm_front import rmm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  output logic           q_valid,
  input  wire logic      q_take,
  output cls_item_t      q_item
);
  cls_item_t   mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        do_push, do_pop;
  cls_item_t   cls;

  assign full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_comb begin
    cls.bits = item.sample_bits;
    cls.pos = item.sample_position;
    cls.finite = (item.sample_bits[62:52] != 11'h7FF);
    cls.last = item.last_in_run;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("front queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_take) |=> full)
    else $error("front queue lost fullness");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> !q_valid)
    else $error("front queue invented an item");
endmodule
`default_nettype wire

/* sv/rmm_back.sv */
// Back stage: updates the running extremes and, on the last sample, loads the
// summary into the output register. Depends on rmm_pkg.
`default_nettype none
module rmm_back import rmm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  output logic            q_take,
  input  wire cls_item_t  q_item,
  output logic            out_empty,
  input  wire logic       out_pop,
  output out_item_t       out_item
);
  logic        seen_r, seen_nxt;
  logic [63:0] max_r, max_nxt, min_r, min_nxt;
  logic [31:0] maxp_r, maxp_nxt, minp_r, minp_nxt, first_r, first_nxt, lat_r, lat_nxt;
  logic [30:0] cnt_r, cnt_nxt;
  logic        ovalid_r;
  out_item_t   oitem_r, sum;
  logic [31:0] p32;

  // The output register may be refilled in the cycle it is popped.
  assign q_take = q_valid && (!ovalid_r || out_pop || !q_item.last);
  assign out_empty = !ovalid_r;
  assign out_item = oitem_r;
  assign p32 = {1'b0, q_item.pos};

  always_comb begin
    seen_nxt = seen_r; max_nxt = max_r; min_nxt = min_r;
    maxp_nxt = maxp_r; minp_nxt = minp_r; first_nxt = first_r; lat_nxt = lat_r;
    cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 31'd1;
    if (q_item.finite) begin
      if (!seen_r) begin
        seen_nxt = 1'b1;
        max_nxt = q_item.bits; min_nxt = q_item.bits;
        maxp_nxt = p32; minp_nxt = p32; first_nxt = p32;
      end else begin
        if (order_key(q_item.bits) > order_key(max_r)) begin
          max_nxt = q_item.bits; maxp_nxt = p32;
        end
        if (order_key(q_item.bits) < order_key(min_r)) begin
          min_nxt = q_item.bits; minp_nxt = p32;
        end
      end
      lat_nxt = p32;
    end
    sum.max_bits = max_nxt;
    sum.min_bits = min_nxt;
    sum.max_position = maxp_nxt;
    sum.min_position = minp_nxt;
    sum.has_finite = seen_nxt;
    sum.first_finite_position = first_nxt;
    sum.last_finite_position = lat_nxt;
    sum.point_count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_take && q_item.last) begin
      oitem_r <= sum;
    end
    if (!rst_n || (q_take && q_item.last)) begin
      seen_r <= 1'b0; max_r <= BITS_PLUS_ONE; min_r <= BITS_MINUS_ONE;
      maxp_r <= NO_POS; minp_r <= NO_POS; first_r <= NO_POS; lat_r <= NO_POS;
      cnt_r <= '0;
    end else if (q_take) begin
      seen_r <= seen_nxt; max_r <= max_nxt; min_r <= min_nxt;
      maxp_r <= maxp_nxt; minp_r <= minp_nxt; first_r <= first_nxt; lat_r <= lat_nxt;
      cnt_r <= cnt_nxt;
    end
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (q_take && q_item.last) begin
      ovalid_r <= 1'b1;
    end else if (out_pop) begin
      ovalid_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_pop) |=> ovalid_r)
    else $error("summary dropped before pop");
  assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (maxp_r == NO_POS && first_r == NO_POS))
    else $error("positions set without a finite sample");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_take && q_item.last) |=> (cnt_r == 31'd0 && !seen_r))
    else $error("run state not cleared after summary");
endmodule
`default_nettype wire

/* sv/running_min_max_finite_samples.sv */
// Path: a closing sample is written into the front queue when it is accepted;
// the back stage then updates the extremes and loads the summary into the output
// register, and a full output register can hold the closing sample in the queue.
// Throughput: one sample per cycle while in_full is low; the two-entry queue and
// output register let each side stall on its own.
// Reset: synchronous active-low rst_n clears the queue, run state and output.
// Depends on rmm_pkg, rmm_front and rmm_back.
`default_nettype none
module running_min_max_finite_samples import rmm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_item
);
  logic      q_valid, q_take;
  cls_item_t q_item;

  rmm_front u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .item(in_item),
    .q_valid, .q_take, .q_item
  );

  rmm_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_item,
    .out_empty, .out_pop, .out_item
  );
endmodule
`default_nettype wire

/* test/testbench.sv */
// Testbench for running_min_max_finite_samples: drives runs of binary64 samples
// through the push/full port and checks each run summary against its own predictor.
// Depends on rmm_pkg and the block's RTL.
`default_nettype none
module testbench;
  import rmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;

  running_min_max_finite_samples dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the run in progress.
  logic        seen_finite;
  logic [63:0] top_bits, bottom_bits;
  logic [31:0] top_pos, bottom_pos, first_pos, latest_pos;
  logic [30:0] sample_count;
  out_item_t   summary_q[$];
  int errors = 0;
  int summaries_seen = 0;
  int samples_sent = 0;
  int cycles = 0;
  bit idle_enable = 1'b1;

  task automatic clear_run();
    seen_finite = 1'b0;
    top_bits = BITS_PLUS_ONE;
    bottom_bits = BITS_MINUS_ONE;
    top_pos = NO_POS;
    bottom_pos = NO_POS;
    first_pos = NO_POS;
    latest_pos = NO_POS;
    sample_count = '0;
  endtask

  function automatic bit is_finite(logic [63:0] b);
    return b[62:52] != 11'h7FF;
  endfunction

  // Total order of finite binary64 values with both zeros equal.
  function automatic bit greater(logic [63:0] a, logic [63:0] b);
    bit az, bz;
    az = a[62:0] == 63'd0;
    bz = b[62:0] == 63'd0;
    if (az && bz) return 1'b0;
    if (az) return b[63];
    if (bz) return !a[63];
    if (a[63] != b[63]) return !a[63];
    if (!a[63]) return a[62:0] > b[62:0];
    return a[62:0] < b[62:0];
  endfunction

  task automatic predict_sample(in_item_t it);
    out_item_t s;
    if (sample_count != COUNT_MAX) sample_count = sample_count + 1'b1;
    if (is_finite(it.sample_bits)) begin
      if (!seen_finite) begin
        seen_finite = 1'b1;
        top_bits = it.sample_bits;
        bottom_bits = it.sample_bits;
        top_pos = {1'b0, it.sample_position};
        bottom_pos = {1'b0, it.sample_position};
        first_pos = {1'b0, it.sample_position};
      end else begin
        if (greater(it.sample_bits, top_bits)) begin
          top_bits = it.sample_bits;
          top_pos = {1'b0, it.sample_position};
        end
        if (greater(bottom_bits, it.sample_bits)) begin
          bottom_bits = it.sample_bits;
          bottom_pos = {1'b0, it.sample_position};
        end
      end
      latest_pos = {1'b0, it.sample_position};
    end
    if (it.last_in_run) begin
      s.max_bits = top_bits;
      s.min_bits = bottom_bits;
      s.max_position = top_pos;
      s.min_position = bottom_pos;
      s.has_finite = seen_finite;
      s.first_finite_position = first_pos;
      s.last_finite_position = latest_pos;
      s.point_count = sample_count;
      summary_q.insert(summary_q.size(), s);
      clear_run();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH summary %0d %s: got %h want %h", summaries_seen, what, got, want);
  endtask

  task automatic send_sample(logic [63:0] bits, logic [30:0] pos, logic last);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_item <= '{sample_bits: bits, sample_position: pos, last_in_run: last};
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_sample('{sample_bits: bits, sample_position: pos, last_in_run: last});
    samples_sent++;
  endtask

  task automatic go_idle();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  // Output: random pop stalls if idle_enable; checks pops against oldest summary.
  initial begin
    out_item_t w;
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (summary_q.size() == 0) begin
          report_mismatch("unexpected summary", 64'd0, 64'd0);
        end else begin
          w = summary_q.pop_front();
          if (out_item.max_bits !== w.max_bits)
            report_mismatch("max_bits", out_item.max_bits, w.max_bits);
          if (out_item.min_bits !== w.min_bits)
            report_mismatch("min_bits", out_item.min_bits, w.min_bits);
          if (out_item.max_position !== w.max_position)
            report_mismatch("max_position", out_item.max_position, w.max_position);
          if (out_item.min_position !== w.min_position)
            report_mismatch("min_position", out_item.min_position, w.min_position);
          if (out_item.has_finite !== w.has_finite)
            report_mismatch("has_finite", out_item.has_finite, w.has_finite);
          if (out_item.first_finite_position !== w.first_finite_position)
            report_mismatch("first_finite_position", out_item.first_finite_position,
                            w.first_finite_position);
          if (out_item.last_finite_position !== w.last_finite_position)
            report_mismatch("last_finite_position", out_item.last_finite_position,
                            w.last_finite_position);
          if (out_item.point_count !== w.point_count)
            report_mismatch("point_count", out_item.point_count, w.point_count);
        end
        summaries_seen++;
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] random_finite();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: b[62:52] = 11'd0;
      1: b[62:52] = 11'h7FE;
      2: b[62:52] = 11'(11'h3FF + $urandom_range(0, 8) - 4);
      3: b[62:0] = 63'd0;
      default: if (b[62:52] == 11'h7FF) b[62] = 1'b0;
    endcase
    return b;
  endfunction

  function automatic logic [63:0] random_sample();
    logic [63:0] b;
    case ($urandom_range(0, 19))
      0: b = {$urandom_range(0, 1) == 1, 11'h7FF, 52'd0};
      1: b = {$urandom_range(0, 1) == 1, 11'h7FF, 20'($urandom), $urandom};
      2: b = {$urandom, $urandom};
      default: b = random_finite();
    endcase
    return b;
  endfunction

  task automatic test_extremes();
    send_sample(64'h7FEFFFFFFFFFFFFF, 31'd0, 1'b0);
    send_sample(64'hFFEFFFFFFFFFFFFF, 31'h7FFFFFFF, 1'b0);
    send_sample(64'h0000000000000001, 31'd5, 1'b0);
    send_sample(64'h8000000000000001, 31'd6, 1'b1);
    send_sample(64'hFFFFFFFFFFFFFFFF, 31'h7FFFFFFF, 1'b1);
  endtask

  task automatic test_no_finite();
    send_sample(64'h7FF0000000000000, 31'd1, 1'b0);
    send_sample(64'hFFF0000000000000, 31'd2, 1'b0);
    send_sample(64'h7FF8000000000000, 31'd3, 1'b1);
  endtask

  task automatic test_ties_and_zeros();
    send_sample(64'h0000000000000000, 31'd10, 1'b0);
    send_sample(64'h8000000000000000, 31'd11, 1'b0);
    send_sample(64'h0000000000000000, 31'd12, 1'b0);
    send_sample(64'h4000000000000000, 31'd3, 1'b0);
    send_sample(64'h4000000000000000, 31'd2, 1'b0);
    send_sample(64'hC000000000000000, 31'd9, 1'b0);
    send_sample(64'hC000000000000000, 31'd1, 1'b0);
    send_sample(64'h7FF0000000000001, 31'd0, 1'b1);
    send_sample(64'h8000000000000000, 31'd4, 1'b1);
  endtask

  task automatic test_random_runs(int n);
    int len, k;
    k = 0;
    while (k < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send_sample(random_sample(), 31'($urandom), i == len - 1);
        k++;
      end
    end
  endtask

  initial begin
    clear_run();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_no_finite();
    test_ties_and_zeros();
    test_random_runs(1400);
    idle_enable = 1'b0;
    test_random_runs(230);
    go_idle();
    while (summary_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d samples; checked %0d run summaries, with infinities, NaN and ties.",
             samples_sent, summaries_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
